FILE: design/assert_macros.svh
// Assertion macros for the row unfilter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRU_ASSERT(lbl, prop, msg)
`define PRU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/pru_pkg.sv
// Types and constants shared by the PNG row unfilter modules
package pru_pkg;

    localparam int BPP_W       = 3;
    localparam int ROW_W       = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int PIX_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    typedef enum logic [0:0] {
        REG_BPP       = 1'b0,
        REG_ROW_BYTES = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // One queued transaction from the front to the back
    typedef struct packed {
        logic       is_err;
        filt_t      filter;
        logic       left_ok;
        logic       top_zero;
        logic       row_end;
        logic [7:0] data;
    } cmd_t;

endpackage

FILE: design/pru_in_if.sv
// Input stream channel: one filtered PNG stream byte per transaction
interface pru_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       image_start;

    modport source (output valid, output in_byte, output image_start, input ready);
    modport sink (input valid, input in_byte, input image_start, output ready);
endinterface

FILE: design/pru_out_if.sv
// Result channel: one reconstructed byte or filter error per transaction
interface pru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_row;
    logic       bad_filter;

    modport source (output valid, output out_byte, output end_of_row, output bad_filter,
                    input ready);
    modport sink (input valid, input out_byte, input end_of_row, input bad_filter,
                  output ready);
endinterface

FILE: design/pru_front.sv
// Front end: accepts stream bytes, tracks row position and queues work for the back end
module pru_front #(
    parameter int AW = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    pru_in_if.sink                     stream,
    input  logic [AW-1:0]              rb_last,
    input  logic [pru_pkg::PIX_W-1:0]  bpp_eff,
    input  logic                       q_full,
    output logic                       push,
    output pru_pkg::cmd_t              push_cmd,
    output logic [AW-1:0]              push_addr
);

    logic            expect_filter_reg;
    logic            expect_filter_next;
    logic            first_row_reg;
    logic            first_row_next;
    pru_pkg::filt_t  filter_reg;
    pru_pkg::filt_t  filter_next;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   idx_next;

    logic            accept;
    logic            col0;
    logic            first_eff;
    logic            bad;
    logic [AW-1:0]   i_clamp;
    logic            is_end;

    assign stream.ready = !q_full;

    always_comb
    begin
        accept    = stream.valid && stream.ready;
        col0      = stream.image_start || expect_filter_reg;
        first_eff = stream.image_start || first_row_reg;
        bad       = stream.in_byte > 8'(pru_pkg::FILT_PAETH);
        // clamp the index if the row was shortened under a row in progress
        i_clamp   = (idx_reg > rb_last) ? rb_last : idx_reg;
        is_end    = (i_clamp == rb_last);

        expect_filter_next = expect_filter_reg;
        first_row_next     = first_row_reg;
        filter_next        = filter_reg;
        idx_next           = idx_reg;

        if (accept)
        begin
            if (col0)
            begin
                expect_filter_next = 1'b0;
                idx_next           = '0;
                first_row_next     = first_eff;
                filter_next        = bad ? pru_pkg::FILT_NONE
                                         : pru_pkg::filt_t'(stream.in_byte[2:0]);
            end
            else if (is_end)
            begin
                expect_filter_next = 1'b1;
                first_row_next     = 1'b0;
            end
            else
            begin
                idx_next = AW'(i_clamp + 1'b1);
            end
        end

        push              = accept && (!col0 || bad);
        push_cmd.is_err   = col0;
        push_cmd.filter   = filter_reg;
        push_cmd.left_ok  = i_clamp >= AW'(bpp_eff);
        push_cmd.top_zero = first_row_reg;
        push_cmd.row_end  = is_end;
        push_cmd.data     = stream.in_byte;
        push_addr         = i_clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_filter_reg <= 1'b1;
            first_row_reg     <= 1'b1;
            filter_reg        <= pru_pkg::FILT_NONE;
            idx_reg           <= '0;
        end
        else
        begin
            expect_filter_reg <= expect_filter_next;
            first_row_reg     <= first_row_next;
            filter_reg        <= filter_next;
            idx_reg           <= idx_next;
        end
    end

endmodule

FILE: design/pru_queue.sv
// Short queue of transactions between the front end and the back end
module pru_queue #(
    parameter int AW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  pru_pkg::cmd_t               push_cmd,
    input  logic [AW-1:0]               push_addr,
    output logic                        full,
    input  logic                        pop,
    output pru_pkg::cmd_t               head_cmd,
    output logic [AW-1:0]               head_addr,
    output logic                        empty,
    output logic [pru_pkg::QLVL_W-1:0]  level
);

    pru_pkg::cmd_t                cmd_mem  [pru_pkg::QUEUE_DEPTH];
    logic [AW-1:0]                addr_mem [pru_pkg::QUEUE_DEPTH];
    logic [pru_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [pru_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [pru_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [pru_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [pru_pkg::QLVL_W-1:0]   level_reg;
    logic [pru_pkg::QLVL_W-1:0]   level_next;

    assign full      = (level_reg == pru_pkg::QLVL_W'(pru_pkg::QUEUE_DEPTH));
    assign empty     = (level_reg == '0);
    assign level     = level_reg;
    assign head_cmd  = cmd_mem[rd_ptr_reg];
    assign head_addr = addr_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pru_pkg::QPTR_W'(pru_pkg::QUEUE_DEPTH - 1))
                        ? '0 : pru_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pru_pkg::QPTR_W'(pru_pkg::QUEUE_DEPTH - 1))
                        ? '0 : pru_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        case ({push, pop})
            2'b10:   level_next = pru_pkg::QLVL_W'(level_reg + 1'b1);
            2'b01:   level_next = pru_pkg::QLVL_W'(level_reg - 1'b1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= push_cmd;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

FILE: design/pru_back.sv
// Back end: line store, pixel lane history, filter reconstruction and result register
module pru_back #(
    parameter int AW              = 10,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pru_pkg::cmd_t              head_cmd,
    input  logic [AW-1:0]              head_addr,
    input  logic                       q_empty,
    output logic                       pop,
    input  logic [pru_pkg::PIX_W-1:0]  bpp_eff,
    pru_out_if.source                  result
);

    localparam int LW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int DEPTH = 2 ** AW;
    localparam int SH    = AW + 3;

    function automatic logic [9:0] abs10(input logic signed [9:0] v);
        return 10'(v[9] ? -v : v);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        pa = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
        pb = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
        pc = abs10($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

    logic [7:0]           line_mem [DEPTH];
    logic [7:0]           rdata_reg;

    logic                 st_valid_reg;
    logic                 st_valid_next;
    pru_pkg::cmd_t        st_cmd_reg;
    logic [AW-1:0]        st_addr_reg;
    logic [LW-1:0]        st_lane_reg;
    logic                 st_fwd_reg;
    logic [7:0]           st_fwd_data_reg;

    logic [7:0]           left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]           upleft_hist_reg [MAX_PIXEL_BYTES];

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_eor_reg;
    logic                 out_bad_reg;

    logic [LW-1:0]        lane_by_k [MAX_PIXEL_BYTES];
    logic [LW-1:0]        head_lane;
    logic                 fire;
    logic                 wr_en;
    logic                 fwd_hit;
    logic [7:0]           a_val;
    logic [7:0]           b_val;
    logic [7:0]           c_val;
    logic [7:0]           pred;
    logic [7:0]           x_val;

    // Lane of the head entry for every pixel size: remainder by reciprocal multiply
    for (genvar k = 1; k <= MAX_PIXEL_BYTES; k++)
    begin : g_lane
        localparam int M = (2 ** SH + k - 1) / k;
        logic [AW+SH:0] prod;
        logic [AW-1:0]  quo;
        logic [AW-1:0]  rem;
        assign prod = (AW+SH+1)'(head_addr) * (AW+SH+1)'(M);
        assign quo  = AW'(prod >> SH);
        assign rem  = AW'(head_addr - AW'(quo * k));
        assign lane_by_k[k-1] = LW'(rem);
    end

    always_comb
    begin
        head_lane = '0;
        for (int j = 0; j < MAX_PIXEL_BYTES; j++)
        begin
            if (bpp_eff == pru_pkg::PIX_W'(j + 1))
                head_lane = lane_by_k[j];
        end
    end

    always_comb
    begin
        fire  = st_valid_reg && (!out_valid_reg || result.ready);
        pop   = !q_empty && (!st_valid_reg || fire);
        wr_en = fire && !st_cmd_reg.is_err;
        // the store returns old data when the entry is written at the same edge
        fwd_hit = wr_en && (head_addr == st_addr_reg);

        a_val = st_cmd_reg.left_ok ? left_hist_reg[st_lane_reg] : 8'd0;
        b_val = st_cmd_reg.top_zero ? 8'd0 : (st_fwd_reg ? st_fwd_data_reg : rdata_reg);
        c_val = (st_cmd_reg.top_zero || !st_cmd_reg.left_ok)
              ? 8'd0 : upleft_hist_reg[st_lane_reg];

        case (st_cmd_reg.filter)
            pru_pkg::FILT_SUB:   pred = a_val;
            pru_pkg::FILT_UP:    pred = b_val;
            pru_pkg::FILT_AVG:   pred = 8'((9'(a_val) + 9'(b_val)) >> 1);
            pru_pkg::FILT_PAETH: pred = paeth_pick(a_val, b_val, c_val);
            default:             pred = 8'd0;
        endcase
        x_val = 8'(st_cmd_reg.data + pred);

        st_valid_next = pop ? 1'b1 : (fire ? 1'b0 : st_valid_reg);
        out_valid_next = fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[st_addr_reg] <= x_val;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rdata_reg <= line_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            st_cmd_reg      <= head_cmd;
            st_addr_reg     <= head_addr;
            st_lane_reg     <= head_lane;
            st_fwd_reg      <= fwd_hit;
            st_fwd_data_reg <= x_val;
        end
        if (fire)
        begin
            out_byte_reg <= st_cmd_reg.is_err ? 8'd0 : x_val;
            out_eor_reg  <= !st_cmd_reg.is_err && st_cmd_reg.row_end;
            out_bad_reg  <= st_cmd_reg.is_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PIXEL_BYTES; j++)
            begin
                left_hist_reg[j]   <= 8'd0;
                upleft_hist_reg[j] <= 8'd0;
            end
        end
        else if (wr_en)
        begin
            left_hist_reg[st_lane_reg]   <= x_val;
            upleft_hist_reg[st_lane_reg] <= b_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.end_of_row = out_eor_reg;
    assign result.bad_filter = out_bad_reg;

endmodule

FILE: design/png_row_unfilter.sv
// PNG scanline filter reconstruction (none, sub, up, average, Paeth), one stream byte per
// transaction. The first byte of each row is the filter type; a type above four yields one
// result with bad_filter set and the row then passes through unfiltered. The block takes one
// byte and gives one result every cycle unless the queue is full or the result side stalls:
// the line store is read once and written once per data byte, and that single read and write
// per cycle sets the rate. A data byte passes through the queue, the stage register and the
// result register before its result is presented; a good filter type byte gives no result.
// A four-entry queue between the front end and the reconstruction back end, and the result
// register, let either side stall without stopping the other until the queue fills or empties.
// The line store needs no clearing after reset: the row above an image's first row reads as zeros.
`include "assert_macros.svh"

module png_row_unfilter #(
    parameter int MAX_ROW_BYTES   = 1024,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pru_in_if.sink                          stream,
    pru_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int CW = (AW + 1 > pru_pkg::ROW_W) ? AW + 1 : pru_pkg::ROW_W;

    logic [pru_pkg::BPP_W-1:0]   bpp_reg;
    logic [pru_pkg::BPP_W-1:0]   bpp_next;
    logic [pru_pkg::ROW_W-1:0]   row_bytes_reg;
    logic [pru_pkg::ROW_W-1:0]   row_bytes_next;

    logic [pru_pkg::PIX_W-1:0]   bpp_eff;
    logic [CW-1:0]               rb_wide;
    logic [AW-1:0]               rb_last;

    logic                        push;
    pru_pkg::cmd_t               push_cmd;
    logic [AW-1:0]               push_addr;
    logic                        q_full;
    logic                        pop;
    pru_pkg::cmd_t               head_cmd;
    logic [AW-1:0]               head_addr;
    logic                        q_empty;
    logic [pru_pkg::QLVL_W-1:0]  q_level;

    always_comb
    begin
        bpp_next       = bpp_reg;
        row_bytes_next = row_bytes_reg;
        if (cfg_we)
        begin
            unique case (pru_pkg::cfg_reg_t'(cfg_index))
                pru_pkg::REG_BPP:       bpp_next = cfg_data[pru_pkg::BPP_W-1:0];
                pru_pkg::REG_ROW_BYTES: row_bytes_next = cfg_data[pru_pkg::ROW_W-1:0];
                default:                bpp_next = bpp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= pru_pkg::BPP_W'(1);
            row_bytes_reg <= pru_pkg::ROW_W'(1024);
        end
        else
        begin
            bpp_reg       <= bpp_next;
            row_bytes_reg <= row_bytes_next;
        end
    end

    // Saturate the pixel size and row length to what the hardware holds
    always_comb
    begin
        if (bpp_reg == '0)
            bpp_eff = pru_pkg::PIX_W'(1);
        else if (pru_pkg::PIX_W'(bpp_reg) > pru_pkg::PIX_W'(MAX_PIXEL_BYTES))
            bpp_eff = pru_pkg::PIX_W'(MAX_PIXEL_BYTES);
        else
            bpp_eff = pru_pkg::PIX_W'(bpp_reg);

        rb_wide = CW'(row_bytes_reg);
        if (rb_wide == '0)
            rb_last = '0;
        else if (rb_wide > CW'(MAX_ROW_BYTES))
            rb_last = AW'(MAX_ROW_BYTES - 1);
        else
            rb_last = AW'(rb_wide - 1'b1);
    end

    pru_front #(
        .AW (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .rb_last   (rb_last),
        .bpp_eff   (bpp_eff),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr)
    );

    pru_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr),
        .full      (q_full),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .head_addr (head_addr),
        .empty     (q_empty),
        .level     (q_level)
    );

    pru_back #(
        .AW              (AW),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .head_addr (head_addr),
        .q_empty   (q_empty),
        .pop       (pop),
        .bpp_eff   (bpp_eff),
        .result    (result)
    );

    `PRU_ASSERT(a_pop_not_empty, pop |-> !q_empty, "back end popped an empty queue")
    `PRU_ASSERT(a_level_range, q_level <= pru_pkg::QLVL_W'(pru_pkg::QUEUE_DEPTH), "queue level out of range")
    `PRU_ASSERT(a_bad_payload, result.valid && result.bad_filter |-> result.out_byte == 8'd0 && !result.end_of_row, "filter error result carries data")
    `PRU_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !result.valid, "result presented during reset")

endmodule
